/* rtl/core/rwct_pkg.sv */
`default_nettype none

package rwct_pkg;

  localparam int unsigned ANGLE_BITS  = 12;
  localparam int unsigned TURN_SHIFT  = 16 - ANGLE_BITS;
  localparam int unsigned TEX_BITS    = 6;
  localparam int unsigned CELL_BITS   = 4;
  localparam int unsigned Q14_BITS    = 14;
  localparam int unsigned FRAC_W      = CELL_BITS + Q14_BITS;
  localparam int unsigned ACC_BITS    = 22;
  localparam int unsigned ACC_SHIFT   = 9;
  localparam int unsigned MAX_HEIGHT  = 2048;
  localparam int unsigned H_RESET     = 720;
  localparam int unsigned Q14_ONE     = 1 << Q14_BITS;
  localparam int unsigned CORDIC_N    = 14;
  localparam int unsigned CORDIC_SEED = 9949;
  localparam int unsigned DIV_BITS    = 38;
  localparam int unsigned NUM_SHIFT   = CELL_BITS + 22;
  localparam int unsigned STP_SHIFT   = TEX_BITS + 24;

  localparam int unsigned QUARTER_TURN = 1 << (ANGLE_BITS - 2);
  localparam int unsigned HALF_TURN    = 1 << (ANGLE_BITS - 1);
  localparam int unsigned THREE_QUARTER_TURN = 3 * QUARTER_TURN;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [1:0] TID_V_FRONT = 2'd0;
  localparam logic [1:0] TID_H_LOW   = 2'd1;
  localparam logic [1:0] TID_H_HIGH  = 2'd2;
  localparam logic [1:0] TID_V_BACK  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CORD1,
    S_MCORR,
    S_DLD1,
    S_DIV1,
    S_DLD2,
    S_DIV2,
    S_CLIP,
    S_MOFF,
    S_SPAN,
    S_CORD2,
    S_MPOS,
    S_TEXC
  } st_e;

  typedef struct packed {
    logic [10:0] column;
    logic [10:0] row;
    logic [1:0]  tex_id;
    logic [5:0]  tex_x;
    logic [5:0]  tex_y;
    logic        last;
  } pix_t;

  // arctangent of 2^-i in 1/65536 turn
  function automatic logic signed [17:0] atan_f(input logic [3:0] i);
    logic signed [17:0] r;
    case (i)
      4'd0:    r = 18'sd8192;
      4'd1:    r = 18'sd4836;
      4'd2:    r = 18'sd2555;
      4'd3:    r = 18'sd1297;
      4'd4:    r = 18'sd651;
      4'd5:    r = 18'sd326;
      4'd6:    r = 18'sd163;
      4'd7:    r = 18'sd81;
      4'd8:    r = 18'sd41;
      4'd9:    r = 18'sd20;
      4'd10:   r = 18'sd10;
      4'd11:   r = 18'sd5;
      4'd12:   r = 18'sd3;
      4'd13:   r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/raycast_wall_column_texturer.sv */
`default_nettype none
// Tick word: its pixel word is registered into the output queue and read from its head;
// one tick per cycle while no ray load runs and the two-entry output queue has room.
// Ray load word: input stalled during two 14-step CORDIC runs and two 38-step restoring
// divisions on the shared divider, plus multiply and setup steps.
// Reset (rst_ni low, asynchronous): sequencer idle, no span active, output queue
// empty, screen height 720.

module raycast_wall_column_texturer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [10:0] column_i,
  input  logic [11:0] ray_angle_i,
  input  logic [11:0] player_angle_i,
  input  logic [15:0] player_x_i,
  input  logic [15:0] player_y_i,
  input  logic [15:0] hit_distance_i,
  input  logic        hit_side_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] pixel_column_o,
  output logic [10:0] pixel_row_o,
  output logic [1:0]  texture_id_o,
  output logic [5:0]  tex_x_o,
  output logic [5:0]  tex_y_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [11:0] cfg_data_i
);
  import rwct_pkg::*;

  st_e state_q, state_d;

  logic [11:0] sh_q;
  logic [11:0] h_eff;

  logic [11:0] ra_q, h_q;
  logic [15:0] dist_q, pos_q;
  logic        side_q;

  logic signed [17:0] cx_q, cy_q, cz_q;
  logic signed [17:0] nx, ny, nz, dx, dy, at;
  logic [3:0]         it_q;
  logic               flip_q;
  logic [11:0]        rel, cord_ang;
  logic [15:0]        a16, az;
  logic               flip0;
  logic signed [17:0] z0;

  logic signed [24:0] mul_a;
  logic signed [22:0] mul_b;
  logic signed [47:0] mul_p, prod_q;

  logic [DIV_BITS-1:0] qn_q;
  logic [30:0]         rem_q, dvs_q, rem_n;
  logic [31:0]         dsh;
  logic [32:0]         trial;
  logic                qb;
  logic [5:0]          dcnt_q;

  logic [23:0] lh_q, off_q;
  logic [19:0] lhc_q, hs;
  logic [20:0] cnt_t;
  logic [11:0] cnt_n;
  logic [19:0] hh;
  logic signed [21:0] yoff;

  logic [FRAC_W-1:0] tsum;

  logic        span_active_q;
  logic [10:0] col_q, top_q;
  logic [1:0]  tex_q;
  logic [5:0]  texcol_q;
  logic [11:0] idx_q, cnt_q;
  logic [ACC_BITS-1:0] acc_q, stp_q;

  logic [1:0] fifo_cnt_q;
  pix_t       e0_q, e1_q, new_pix;
  logic       in_acc, load_acc, tick_acc, push, pop;
  logic       cord_last, div_last;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (sh_q == 12'd0) begin
      h_eff = 12'd1;
    end else if (sh_q > 12'(MAX_HEIGHT)) begin
      h_eff = 12'(MAX_HEIGHT);
    end else begin
      h_eff = sh_q;
    end
  end

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign load_acc = in_acc & (func_i == FUNC_LOAD);
  assign tick_acc = in_acc & (func_i == FUNC_TICK) & span_active_q;
  assign push     = tick_acc;
  assign pop      = (fifo_cnt_q != 2'd0) & ~out_stall_i;

  assign cord_last = (it_q == 4'(CORDIC_N - 1));
  assign div_last  = (dcnt_q == 6'(DIV_BITS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (load_acc) state_d = S_CORD1;
      S_CORD1: if (cord_last) state_d = S_MCORR;
      S_MCORR: state_d = S_DLD1;
      S_DLD1:  state_d = S_DIV1;
      S_DIV1:  if (div_last) state_d = S_DLD2;
      S_DLD2:  state_d = S_DIV2;
      S_DIV2:  if (div_last) state_d = S_CLIP;
      S_CLIP:  state_d = S_MOFF;
      S_MOFF:  state_d = S_SPAN;
      S_SPAN:  state_d = S_CORD2;
      S_CORD2: if (cord_last) state_d = S_MPOS;
      S_MPOS:  state_d = S_TEXC;
      S_TEXC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = (state_q != S_IDLE) | (fifo_cnt_q == 2'd2);
    cord_ang   = ra_q;
    mul_a      = $signed({9'd0, dist_q});
    mul_b      = $signed({{5{cx_q[17]}}, cx_q});
    unique case (state_q)
      S_IDLE: cord_ang = rel;
      S_MOFF: begin
        mul_a = $signed({1'b0, off_q});
        mul_b = $signed({1'b0, stp_q});
      end
      S_MPOS: begin
        if (side_q) begin
          mul_b = $signed({{5{cx_q[17]}}, cx_q});
        end else begin
          mul_b = $signed({{5{cy_q[17]}}, cy_q});
        end
      end
      default: ;
    endcase
  end

  assign rel   = ray_angle_i - player_angle_i;
  assign a16   = 16'(cord_ang) << TURN_SHIFT;
  assign flip0 = a16[15] ^ a16[14];
  assign az    = a16 ^ {flip0, 15'd0};
  assign z0    = $signed({{2{az[15]}}, az});

  // CORDIC rotation step
  always_comb begin
    dx = cy_q >>> it_q;
    dy = cx_q >>> it_q;
    at = atan_f(it_q);
    if (!cz_q[17]) begin
      nx = cx_q - dx;
      ny = cy_q + dy;
      nz = cz_q - at;
    end else begin
      nx = cx_q + dx;
      ny = cy_q - dy;
      nz = cz_q + at;
    end
    if (cord_last && flip_q) begin
      nx = -nx;
      ny = -ny;
    end
  end

  assign mul_p = mul_a * mul_b;

  // restoring divider step
  assign dsh   = {rem_q, qn_q[DIV_BITS-1]};
  assign trial = {1'b0, dsh} - {2'd0, dvs_q};
  assign qb    = ~trial[32];
  assign rem_n = qb ? trial[30:0] : dsh[30:0];

  assign hs    = {h_q, 8'd0};
  assign cnt_t = {1'b0, lhc_q} + 21'd255;
  assign cnt_n = (cnt_t[19:8] == 12'd0) ? 12'd1 : cnt_t[19:8];
  assign hh    = {h_q[11:1], 9'd0};
  assign yoff  = $signed({2'd0, hh}) - $signed({2'd0, lhc_q});
  assign tsum  = {pos_q[CELL_BITS-1:0], Q14_BITS'(0)} + prod_q[FRAC_W-1:0];

  always_comb begin
    new_pix.column = col_q;
    new_pix.row    = 11'({1'b0, top_q} + idx_q);
    new_pix.tex_id = tex_q;
    new_pix.tex_x  = texcol_q;
    new_pix.tex_y  = acc_q[ACC_BITS-1 -: TEX_BITS];
    new_pix.last   = (({1'b0, idx_q} + 13'd1) >= {1'b0, cnt_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      sh_q          <= 12'(H_RESET);
      span_active_q <= 1'b0;
      fifo_cnt_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        sh_q <= cfg_data_i;
      end
      if (state_q == S_TEXC) begin
        span_active_q <= 1'b1;
      end else if (push && new_pix.last) begin
        span_active_q <= 1'b0;
      end
      fifo_cnt_q <= fifo_cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // output queue
  always_ff @(posedge clk_i) begin
    if (push && ((fifo_cnt_q == 2'd0) || ((fifo_cnt_q == 2'd1) && pop))) begin
      e0_q <= new_pix;
    end else if (pop && (fifo_cnt_q == 2'd2)) begin
      e0_q <= e1_q;
    end
    if (push && (fifo_cnt_q == 2'd1) && !pop) begin
      e1_q <= new_pix;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (load_acc) begin
          ra_q   <= ray_angle_i;
          dist_q <= hit_distance_i;
          pos_q  <= hit_side_i ? player_x_i : player_y_i;
          side_q <= hit_side_i;
          h_q    <= h_eff;
          col_q  <= column_i;
          if (!hit_side_i) begin
            tex_q <= ((ray_angle_i <= 12'(QUARTER_TURN)) ||
                      (ray_angle_i > 12'(THREE_QUARTER_TURN))) ? TID_V_FRONT : TID_V_BACK;
          end else begin
            tex_q <= ((ray_angle_i != 12'd0) && (ray_angle_i < 12'(HALF_TURN))) ?
                     TID_H_LOW : TID_H_HIGH;
          end
          cx_q   <= 18'(CORDIC_SEED);
          cy_q   <= 18'sd0;
          cz_q   <= z0;
          flip_q <= flip0;
          it_q   <= 4'd0;
        end
        if (tick_acc) begin
          acc_q <= acc_q + stp_q;
          idx_q <= idx_q + 12'd1;
        end
      end
      S_CORD1, S_CORD2: begin
        cx_q <= nx;
        cy_q <= ny;
        cz_q <= nz;
        it_q <= it_q + 4'd1;
      end
      S_MCORR, S_MOFF, S_MPOS: prod_q <= mul_p;
      S_DLD1: begin
        dvs_q  <= (prod_q < $signed(48'(Q14_ONE))) ? 31'(Q14_ONE) : prod_q[30:0];
        qn_q   <= DIV_BITS'(h_q) << NUM_SHIFT;
        rem_q  <= 31'd0;
        dcnt_q <= 6'd0;
      end
      S_DIV1, S_DIV2: begin
        qn_q   <= {qn_q[DIV_BITS-2:0], qb};
        rem_q  <= rem_n;
        dcnt_q <= dcnt_q + 6'd1;
      end
      S_DLD2: begin
        lh_q   <= qn_q[23:0];
        dvs_q  <= 31'(qn_q[23:0]);
        qn_q   <= DIV_BITS'(1) << STP_SHIFT;
        rem_q  <= 31'd0;
        dcnt_q <= 6'd0;
      end
      S_CLIP: begin
        // zero height divides to all ones and saturates like the others
        stp_q <= (|qn_q[DIV_BITS-1:ACC_BITS]) ? '1 : qn_q[ACC_BITS-1:0];
        if (lh_q > {4'd0, hs}) begin
          off_q <= lh_q - {4'd0, hs};
          lhc_q <= hs;
        end else begin
          off_q <= 24'd0;
          lhc_q <= lh_q[19:0];
        end
      end
      S_SPAN: begin
        acc_q  <= prod_q[ACC_SHIFT+ACC_BITS-1:ACC_SHIFT];
        cnt_q  <= cnt_n;
        idx_q  <= 12'd0;
        top_q  <= yoff[21] ? 11'd0 : yoff[19:9];
        cx_q   <= 18'(CORDIC_SEED);
        cy_q   <= 18'sd0;
        cz_q   <= z0;
        flip_q <= flip0;
        it_q   <= 4'd0;
      end
      S_TEXC: texcol_q <= tsum[FRAC_W-1 -: TEX_BITS];
      default: ;
    endcase
  end

  assign out_valid_o    = (fifo_cnt_q != 2'd0);
  assign pixel_column_o = e0_q.column;
  assign pixel_row_o    = e0_q.row;
  assign texture_id_o   = e0_q.tex_id;
  assign tex_x_o        = e0_q.tex_x;
  assign tex_y_o        = e0_q.tex_y;
  assign last_o         = e0_q.last;

`ifndef SYNTHESIS
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt_q != 2'd2) || pop)
    else $error("pixel word pushed into full queue");

  a_last_ends_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && new_pix.last) |=> !span_active_q)
    else $error("span still active after last pixel");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TEXC) |=> (state_q == S_IDLE) && span_active_q)
    else $error("ray load did not open a span");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIV1) || (state_q == S_DIV2)) |-> (dcnt_q < 6'(DIV_BITS)))
    else $error("divider step count out of range");
`endif

endmodule

`default_nettype wire

/* sim/raycast_wall_column_texturer_tb.sv */
module raycast_wall_column_texturer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rwct_pkg::*;

  localparam int SETTLE_CYCLES = 160;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_TICKS = 40;
  localparam logic [21:0] ACC_ALL = 22'h3FFFFF;
  localparam longint UNIT_Q14 = 16384;
  localparam longint CELL_SPAN_Q14 = 16 * 16384;

  typedef struct packed {
    logic        func;
    logic [10:0] column;
    logic [11:0] ray_angle;
    logic [11:0] player_angle;
    logic [15:0] player_x;
    logic [15:0] player_y;
    logic [15:0] hit_distance;
    logic        hit_side;
  } ray_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = FUNC_TICK;
  logic [10:0] column_i = '0;
  logic [11:0] ray_angle_i = '0;
  logic [11:0] player_angle_i = '0;
  logic [15:0] player_x_i = '0;
  logic [15:0] player_y_i = '0;
  logic [15:0] hit_distance_i = '0;
  logic        hit_side_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [10:0] pixel_column_o;
  logic [10:0] pixel_row_o;
  logic [1:0]  texture_id_o;
  logic [5:0]  tex_x_o;
  logic [5:0]  tex_y_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [11:0] cfg_data_i = '0;

  // predicted block state
  logic [11:0] screen_h = 12'(H_RESET);
  bit          span_on = 1'b0;
  logic [10:0] span_col = '0;
  logic [10:0] span_top = '0;
  logic [1:0]  span_tex = '0;
  logic [5:0]  span_texcol = '0;
  logic [11:0] span_idx = '0;
  logic [11:0] span_len = '0;
  logic [21:0] row_acc = '0;
  logic [21:0] row_step = '0;

  pix_t pending_pixels[$];
  pix_t due_pixel;
  int   errors = 0;
  int   quiet_cycles = 0;
  int   send_idle_pct = 29;
  int   recv_idle_pct = 59;

  raycast_wall_column_texturer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .column_i       (column_i),
    .ray_angle_i    (ray_angle_i),
    .player_angle_i (player_angle_i),
    .player_x_i     (player_x_i),
    .player_y_i     (player_y_i),
    .hit_distance_i (hit_distance_i),
    .hit_side_i     (hit_side_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_column_o (pixel_column_o),
    .pixel_row_o    (pixel_row_o),
    .texture_id_o   (texture_id_o),
    .tex_x_o        (tex_x_o),
    .tex_y_o        (tex_y_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int cordic_atan(input int i);
    int r;
    case (i)
      0:       r = 8192;
      1:       r = 4836;
      2:       r = 2555;
      3:       r = 1297;
      4:       r = 651;
      5:       r = 326;
      6:       r = 163;
      7:       r = 81;
      8:       r = 41;
      9:       r = 20;
      10:      r = 10;
      11:      r = 5;
      12:      r = 3;
      13:      r = 1;
      default: r = 0;
    endcase
    return r;
  endfunction

  // Q1.14 cosine and sine of a 16-bit turn angle
  function automatic void cordic_turn16(input logic [15:0] ang, output int c, output int s);
    logic [15:0] a;
    int x, y, z, dx, dy, i;
    bit flip;
    a = ang;
    flip = 1'b0;
    if (a >= 16'd16384 && a < 16'd49152) begin
      a = a + 16'd32768;
      flip = 1'b1;
    end
    z = (a >= 16'd32768) ? int'(a) - 65536 : int'(a);
    x = CORDIC_SEED;
    y = 0;
    for (i = 0; i < CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - cordic_atan(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + cordic_atan(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic int unsigned clamped_height();
    int unsigned hh;
    hh = screen_h;
    if (hh < 1) hh = 1;
    if (hh > MAX_HEIGHT) hh = MAX_HEIGHT;
    return hh;
  endfunction

  function automatic void project_ray(input ray_word_t w);
    int unsigned hh;
    logic [11:0] rel;
    int fc, fs, rc, rs;
    longint corr, pos, r, yoff;
    longint unsigned lh, stp, off, cnt, frac;
    hh = clamped_height();
    rel = w.ray_angle - w.player_angle;
    cordic_turn16({rel, 4'b0000}, fc, fs);
    corr = longint'(w.hit_distance) * longint'(fc);
    if (corr < UNIT_Q14) corr = UNIT_Q14;
    lh = ((64'd16 * hh) << 22) / unsigned'(corr);
    if (lh == 0) stp = ACC_ALL;
    else stp = (64'd64 << 24) / lh;
    if (stp > ACC_ALL) stp = ACC_ALL;
    off = 0;
    if (lh > 64'd256 * hh) begin
      off = lh - 64'd256 * hh;
      lh = 64'd256 * hh;
    end
    row_step = stp[21:0];
    row_acc = 22'((stp * off) >> 9);
    cnt = (lh + 64'd255) >> 8;
    if (cnt == 0) cnt = 1;
    span_len = cnt[11:0];
    span_idx = '0;
    yoff = longint'(hh >> 1) * 512 - longint'(lh);
    span_top = (yoff < 0) ? 11'd0 : 11'(yoff >>> 9);

    cordic_turn16({w.ray_angle, 4'b0000}, rc, rs);
    if (w.hit_side == 1'b0)
      pos = longint'(w.player_y) * 16384 + longint'(w.hit_distance) * longint'(rs);
    else
      pos = longint'(w.player_x) * 16384 + longint'(w.hit_distance) * longint'(rc);
    r = pos % CELL_SPAN_Q14;
    if (r < 0) r = r + CELL_SPAN_Q14;
    frac = (unsigned'(r) * 64'd64) / unsigned'(CELL_SPAN_Q14);
    if (frac > 63) frac = 63;
    span_texcol = frac[5:0];

    if (w.hit_side == 1'b0)
      span_tex = (w.ray_angle <= QUARTER_TURN || w.ray_angle > THREE_QUARTER_TURN) ?
                 TID_V_FRONT : TID_V_BACK;
    else
      span_tex = (w.ray_angle > 0 && w.ray_angle < HALF_TURN) ? TID_H_LOW : TID_H_HIGH;
    span_col = w.column;
    span_on = 1'b1;
  endfunction

  function automatic void step_span();
    pix_t pix;
    bit fin;
    if (!span_on) return;
    fin = (int'(span_idx) + 1 >= int'(span_len));
    pix.column = span_col;
    pix.row    = span_top + 11'(span_idx);
    pix.tex_id = span_tex;
    pix.tex_x  = span_texcol;
    pix.tex_y  = row_acc[21:16];
    pix.last   = fin;
    pending_pixels.push_back(pix);
    row_acc  = row_acc + row_step;
    span_idx = span_idx + 12'd1;
    if (fin) span_on = 1'b0;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic ray_word_t random_word(input logic f);
    ray_word_t w;
    w.func         = f;
    w.column       = 11'($urandom);
    w.ray_angle    = 12'($urandom);
    w.player_angle = 12'($urandom);
    w.player_x     = 16'($urandom);
    w.player_y     = 16'($urandom);
    w.hit_distance = 16'($urandom);
    w.hit_side     = 1'($urandom);
    return w;
  endfunction

  // mostly forward-facing rays with spans of a few dozen rows
  function automatic ray_word_t random_ray();
    ray_word_t w;
    int unsigned hh, lo, d, pick;
    w = random_word(FUNC_LOAD);
    hh = clamped_height();
    if ($urandom_range(7) != 0)
      w.player_angle = w.ray_angle + 12'($urandom_range(1000)) - 12'd500;
    pick = $urandom_range(7);
    if (pick == 0) begin
      w.hit_distance = 16'($urandom_range(40));
    end else if (pick < 6) begin
      lo = (16 * hh) / 32 + 1;
      d = lo * $urandom_range(8, 1) + $urandom_range(lo);
      if (d > 65535) d = 65535;
      w.hit_distance = 16'(d);
    end
    return w;
  endfunction

  task automatic send_word(input ray_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= w.func;
    column_i       <= w.column;
    ray_angle_i    <= w.ray_angle;
    player_angle_i <= w.player_angle;
    player_x_i     <= w.player_x;
    player_y_i     <= w.player_y;
    hit_distance_i <= w.hit_distance;
    hit_side_i     <= w.hit_side;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (w.func == FUNC_LOAD) project_ray(w);
    else step_span();
  endtask

  // ticks for the span just loaded, capped, plus stray ticks past its end
  task automatic send_span(input int max_ticks, input int extra, output int emitted);
    int n, k;
    n = int'(span_len);
    if (n > max_ticks) n = max_ticks;
    for (k = 0; k < n + extra; k++) send_word(random_word(FUNC_TICK));
    emitted = n;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_screen_height(input logic [11:0] v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    screen_h = v;
  endtask

  task automatic test_tick_without_span();
    send_word(random_word(FUNC_TICK));
    send_word(random_word(FUNC_TICK));
  endtask

  task automatic test_field_extremes();
    ray_word_t w;
    int n;
    // zero distance clamps to one unit; the full-height span is cut short by the next load
    w = '0;
    w.func = FUNC_LOAD;
    send_word(w);
    send_span(1, 0, n);
    w = '1;
    w.func = FUNC_LOAD;
    send_word(w);
    send_span(4, 1, n);
  endtask

  task automatic test_texture_quadrants();
    ray_word_t w;
    int k, n;
    for (k = 0; k < 8; k++) begin
      w = random_word(FUNC_LOAD);
      case (k)
        0:       w.ray_angle = 12'(QUARTER_TURN);
        1:       w.ray_angle = 12'(QUARTER_TURN + 1);
        2:       w.ray_angle = 12'(THREE_QUARTER_TURN);
        3:       w.ray_angle = 12'(THREE_QUARTER_TURN + 1);
        4:       w.ray_angle = 12'd0;
        5:       w.ray_angle = 12'd1;
        6:       w.ray_angle = 12'(HALF_TURN - 1);
        default: w.ray_angle = 12'(HALF_TURN);
      endcase
      w.player_angle = w.ray_angle;
      w.hit_distance = 16'd1024;
      w.hit_side = (k >= 4);
      send_word(w);
      send_span(1, 0, n);
    end
  endtask

  task automatic test_ray_behind_viewer();
    ray_word_t w;
    int n;
    w = random_word(FUNC_LOAD);
    w.player_angle = w.ray_angle + 12'(HALF_TURN);
    w.hit_distance = 16'd200;
    send_word(w);
    send_span(1, 0, n);
    w = random_word(FUNC_LOAD);
    w.player_angle = w.ray_angle + 12'(QUARTER_TURN);
    w.hit_distance = 16'hFFFF;
    send_word(w);
    send_span(1, 0, n);
  endtask

  task automatic test_odd_height_clip();
    ray_word_t w;
    int n;
    write_screen_height(12'd3);
    w = random_word(FUNC_LOAD);
    w.player_angle = w.ray_angle;
    w.hit_distance = 16'd1;
    send_word(w);
    send_span(8, 1, n);
    // zero saturates to one row
    write_screen_height(12'd0);
    send_word(random_ray());
    send_span(2, 1, n);
  endtask

  task automatic run_random_segment(input logic [11:0] height, input int quota);
    int sent, cap, extra, n;
    write_screen_height(height);
    sent = 0;
    while (sent < quota) begin
      send_word(random_ray());
      cap = ($urandom_range(3) == 0) ? int'($urandom_range(MAX_TICKS)) : MAX_TICKS;
      extra = ($urandom_range(5) == 0) ? int'($urandom_range(2, 1)) : 0;
      send_span(cap, extra, n);
      sent += 1 + n;
    end
  endtask

  task automatic test_random_traffic();
    int ph;
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      run_random_segment(12'($urandom_range(200, 1)), 80);
      run_random_segment(12'($urandom_range(2048, 201)), 80);
      case (ph)
        0:       run_random_segment(12'd2048, 80);
        1:       run_random_segment(12'd1, 80);
        default: run_random_segment(12'hFFF, 80);
      endcase
    end
  endtask

  // result checking and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel word with nothing pending, actual column %0d row %0d",
                 $time, pixel_column_o, pixel_row_o);
        errors++;
      end else begin
        due_pixel = pending_pixels.pop_front();
        check_field("pixel_column", due_pixel.column, pixel_column_o);
        check_field("pixel_row", due_pixel.row, pixel_row_o);
        check_field("texture_id", due_pixel.tex_id, texture_id_o);
        check_field("tex_x", due_pixel.tex_x, tex_x_o);
        check_field("tex_y", due_pixel.tex_y, tex_y_o);
        check_field("last", due_pixel.last, last_o);
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, %0d pixel words still pending", $time, pending_pixels.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_tick_without_span();
    test_field_extremes();
    test_texture_quadrants();
    test_ray_behind_viewer();
    test_odd_height_clip();
    test_random_traffic();
    wait_idle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/rwct_pkg.sv
rtl/core/raycast_wall_column_texturer.sv
sim/raycast_wall_column_texturer_tb.sv
